FILE: rtl/xtea16_pkg.sv
// Package for the reduced XTEA cipher: widths, round count, register indexes,
// command codes and the structs passed between the pipeline stages.
// No dependencies.
`timescale 1ns / 1ps

package xtea16_pkg;

  localparam int ROUNDS     = 16;
  localparam int NUM_STAGES = 2 * ROUNDS;
  localparam int HALF_W     = 16;
  localparam int BLOCK_W    = 2 * HALF_W;
  localparam int CFG_IDX_W  = 2;

  typedef logic [HALF_W-1:0]    half_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KEY_ZERO = 2'd0;
  localparam cfg_idx_t CFG_KEY_ONE  = 2'd1;
  localparam cfg_idx_t CFG_DELTA    = 2'd2;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam half_t KEY_ZERO_RST = 16'hBEEF;
  localparam half_t KEY_ONE_RST  = 16'hBABE;
  localparam half_t DELTA_RST    = 16'h9E37;

  typedef struct packed {
    half_t key_zero;
    half_t key_one;
    half_t delta;
  } key_cfg_t;

  // phase is 0 on the first half of a round and 1 on the second.
  typedef struct packed {
    logic  cmd;
    logic  phase;
    half_t sum;
    half_t v0;
    half_t v1;
  } stage_data_t;

endpackage

FILE: rtl/xtea16_round.sv
// One half-round stage of the reduced XTEA pipeline, with its own register
// and valid bit. Depends on xtea16_pkg.
`timescale 1ns / 1ps

module xtea16_round (
  input  logic                     clk,
  input  logic                     rst_n,
  input  xtea16_pkg::key_cfg_t     cfg,
  input  logic                     up_valid,
  input  xtea16_pkg::stage_data_t  up_data,
  output logic                     up_ready,
  output logic                     dn_valid,
  output xtea16_pkg::stage_data_t  dn_data,
  input  logic                     dn_ready
);

  logic                    valid_r;
  xtea16_pkg::stage_data_t data_r;
  xtea16_pkg::stage_data_t data_nxt;

  logic              src_is_v1;
  xtea16_pkg::half_t src;
  xtea16_pkg::half_t tgt;
  xtea16_pkg::half_t key;
  xtea16_pkg::half_t mix;
  xtea16_pkg::half_t tgt_nxt;

  // Encryption mixes v1 into v0 first; decryption undoes the second half first.
  always_comb begin
    src_is_v1 = !(up_data.phase ^ up_data.cmd);
    src       = src_is_v1 ? up_data.v1 : up_data.v0;
    tgt       = src_is_v1 ? up_data.v0 : up_data.v1;
    key       = (src_is_v1 ? up_data.sum[0] : up_data.sum[11]) ? cfg.key_one : cfg.key_zero;
    mix       = (((src << 4) ^ (src >> 5)) + src) ^ (up_data.sum + key);
    tgt_nxt   = (up_data.cmd == xtea16_pkg::CMD_DECRYPT) ? (tgt - mix) : (tgt + mix);

    data_nxt       = up_data;
    data_nxt.phase = !up_data.phase;
    if (src_is_v1) begin
      data_nxt.v0 = tgt_nxt;
    end else begin
      data_nxt.v1 = tgt_nxt;
    end
    if (!up_data.phase) begin
      data_nxt.sum = (up_data.cmd == xtea16_pkg::CMD_DECRYPT) ?
                     (up_data.sum - cfg.delta) : (up_data.sum + cfg.delta);
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: rtl/xtea16_block_cipher.sv
// Top level of the reduced XTEA cipher: configuration registers, entry logic
// and a chain of half-round stages. Depends on xtea16_pkg and xtea16_round.
//
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_stall   in_command, in_block_in
//  out_     output     out_valid / out_stall out_block_out
//  cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// There is one register per half-round; a new transaction may enter in every
// cycle in which in_stall is low.
// Reset clears the valid bits and loads the key and delta registers.
// Stages only hold when the stage after them is full and held, so bubbles
// close up and a stalled output does not block input until the chain fills.
`timescale 1ns / 1ps

module xtea16_block_cipher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_command,
  input  logic [xtea16_pkg::BLOCK_W-1:0]  in_block_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [xtea16_pkg::BLOCK_W-1:0]  out_block_out,
  input  logic                            cfg_we,
  input  xtea16_pkg::cfg_idx_t            cfg_index,
  input  xtea16_pkg::half_t               cfg_wdata
);

  xtea16_pkg::key_cfg_t    cfg_r;
  xtea16_pkg::stage_data_t entry_data;
  xtea16_pkg::half_t       dec_start;

  logic                    valid_s [0:xtea16_pkg::NUM_STAGES];
  logic                    ready_s [0:xtea16_pkg::NUM_STAGES];
  xtea16_pkg::stage_data_t data_s  [0:xtea16_pkg::NUM_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_zero <= xtea16_pkg::KEY_ZERO_RST;
      cfg_r.key_one  <= xtea16_pkg::KEY_ONE_RST;
      cfg_r.delta    <= xtea16_pkg::DELTA_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        xtea16_pkg::CFG_KEY_ZERO: cfg_r.key_zero <= cfg_wdata;
        xtea16_pkg::CFG_KEY_ONE:  cfg_r.key_one  <= cfg_wdata;
        xtea16_pkg::CFG_DELTA:    cfg_r.delta    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decryption starts from the sum that encryption ends on.
  always_comb begin
    dec_start        = xtea16_pkg::half_t'(32'(cfg_r.delta) * 32'(xtea16_pkg::ROUNDS));
    entry_data.cmd   = in_command;
    entry_data.phase = 1'b0;
    entry_data.sum   = (in_command == xtea16_pkg::CMD_DECRYPT) ? dec_start : '0;
    entry_data.v0    = in_block_in[xtea16_pkg::HALF_W-1:0];
    entry_data.v1    = in_block_in[xtea16_pkg::BLOCK_W-1:xtea16_pkg::HALF_W];
  end

  assign valid_s[0] = in_valid;
  assign data_s[0]  = entry_data;
  assign in_stall   = !ready_s[0];

  for (genvar k = 0; k < xtea16_pkg::NUM_STAGES; k++) begin : g_stage
    xtea16_round u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (cfg_r),
      .up_valid (valid_s[k]),
      .up_data  (data_s[k]),
      .up_ready (ready_s[k]),
      .dn_valid (valid_s[k+1]),
      .dn_data  (data_s[k+1]),
      .dn_ready (ready_s[k+1])
    );
  end

  assign ready_s[xtea16_pkg::NUM_STAGES] = !out_stall;
  assign out_valid     = valid_s[xtea16_pkg::NUM_STAGES];
  assign out_block_out = {data_s[xtea16_pkg::NUM_STAGES].v1,
                          data_s[xtea16_pkg::NUM_STAGES].v0};

  // An empty first stage must always take a new transaction.
  a_entry_free: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_s[1] |-> !in_stall)
    else $error("input stalled while the first stage is empty");

  // An accepted transaction lands in the first stage.
  a_entry_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> valid_s[1])
    else $error("accepted transaction missing from the first stage");

  // Every result has passed through an even number of half-rounds.
  a_out_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !data_s[xtea16_pkg::NUM_STAGES].phase)
    else $error("result left the pipeline after half a round");

endmodule

FILE: bench/xtea16_block_cipher_checker.sv
// Checker for the reduced XTEA cipher: tracks the key and delta registers,
// predicts the block for every accepted input transaction and compares results.
// Depends on xtea16_pkg.
`timescale 1ns / 1ps

module xtea16_block_cipher_checker
  import xtea16_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_command,
  input  logic [BLOCK_W-1:0] in_block_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [BLOCK_W-1:0] out_block_out,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  half_t              cfg_wdata,
  output int                 mismatches,
  output int                 blocks_pending
);

  half_t key_zero_q = KEY_ZERO_RST;
  half_t key_one_q  = KEY_ONE_RST;
  half_t delta_q    = DELTA_RST;

  logic [BLOCK_W-1:0] predicted_blocks [$];
  int                 mismatch_count = 0;
  int                 result_count   = 0;

  initial begin
    mismatches     = 0;
    blocks_pending = 0;
  end

  function automatic half_t feistel_mix(half_t v, half_t rsum, half_t key);
    return (((v << 4) ^ (v >> 5)) + v) ^ (rsum + key);
  endfunction

  function automatic logic [BLOCK_W-1:0] xtea16_predict(logic cmd,
                                                        logic [BLOCK_W-1:0] blk);
    half_t v0;
    half_t v1;
    half_t rsum;
    v0 = blk[HALF_W-1:0];
    v1 = blk[BLOCK_W-1:HALF_W];
    if (cmd == CMD_DECRYPT) begin
      rsum = half_t'(delta_q * ROUNDS);
      for (int r = 0; r < ROUNDS; r++) begin
        v1   = v1 - feistel_mix(v0, rsum, rsum[11] ? key_one_q : key_zero_q);
        rsum = rsum - delta_q;
        v0   = v0 - feistel_mix(v1, rsum, rsum[0] ? key_one_q : key_zero_q);
      end
    end else begin
      rsum = '0;
      for (int r = 0; r < ROUNDS; r++) begin
        v0   = v0 + feistel_mix(v1, rsum, rsum[0] ? key_one_q : key_zero_q);
        rsum = rsum + delta_q;
        v1   = v1 + feistel_mix(v0, rsum, rsum[11] ? key_one_q : key_zero_q);
      end
    end
    return {v1, v0};
  endfunction

  task automatic report_mismatch(string what, logic [BLOCK_W-1:0] got,
                                 logic [BLOCK_W-1:0] want);
    $display("%0t: result %0d %s: got %08h, expected %08h",
             $realtime, result_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    logic [BLOCK_W-1:0] want;
    if (!rst_n) begin
      key_zero_q = KEY_ZERO_RST;
      key_one_q  = KEY_ONE_RST;
      delta_q    = DELTA_RST;
      predicted_blocks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_ZERO: key_zero_q = cfg_wdata;
          CFG_KEY_ONE:  key_one_q  = cfg_wdata;
          CFG_DELTA:    delta_q    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predicted_blocks.push_back(xtea16_predict(in_command, in_block_in));
      if (out_valid && !out_stall) begin
        if (predicted_blocks.size() == 0) begin
          report_mismatch("arrived with nothing outstanding", out_block_out, 'x);
        end else begin
          want = predicted_blocks.pop_front();
          if (out_block_out !== want)
            report_mismatch("block_out differs", out_block_out, want);
        end
        result_count++;
      end
    end
    // Published with nonblocking updates so the bench sees pre-edge values.
    mismatches     <= mismatch_count;
    blocks_pending <= predicted_blocks.size();
  end

endmodule

FILE: bench/xtea16_block_cipher_tb.sv
// Top of the reduced XTEA cipher testbench: clock, reset, stimulus, output
// back-pressure, watchdog and verdict. Depends on xtea16_pkg, the block and
// xtea16_block_cipher_checker.
`timescale 1ns / 1ps

module xtea16_block_cipher_tb;
  import xtea16_pkg::*;

  localparam cfg_idx_t CFG_SPARE  = 2'd3;
  localparam int       IDLE_LIMIT = 3000;
  localparam int       HOLD_LEN   = 300;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               in_command    = CMD_ENCRYPT;
  logic [BLOCK_W-1:0] in_block_in   = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [BLOCK_W-1:0] out_block_out;
  logic               cfg_we        = 1'b0;
  cfg_idx_t           cfg_index     = CFG_KEY_ZERO;
  half_t              cfg_wdata     = '0;

  int mismatches;
  int blocks_pending;
  int idle_cycles = 0;
  bit gaps_on     = 1'b0;
  int hold_cycles = 0;

  xtea16_block_cipher i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_block_in   (in_block_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_block_out (out_block_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  xtea16_block_cipher_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_block_in    (in_block_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_block_out  (out_block_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .blocks_pending (blocks_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Any stretch with no transaction and no register write this long is a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("xtea16_block_cipher test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a drawn stall before each transaction, or one long hold-off.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = gaps_on ? $urandom_range(0, 11) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Leaves in_valid high on return so back-to-back transactions stay seamless.
  task automatic send_block(logic cmd, logic [BLOCK_W-1:0] blk);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_block_in <= blk;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (blocks_pending != 0) @(posedge clk);
  endtask

  task automatic reg_write(cfg_idx_t idx, half_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // The spare index sits between real writes and must leave them untouched.
  task automatic program_cipher(half_t k0, half_t k1, half_t dl);
    reg_write(CFG_KEY_ZERO, k0);
    reg_write(CFG_SPARE, half_t'($urandom));
    reg_write(CFG_KEY_ONE, k1);
    reg_write(CFG_DELTA, dl);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [BLOCK_W-1:0] pick_block();
    logic [BLOCK_W-1:0] r;
    r = $urandom;
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return {16'h0000, r[15:0]};
      3:       return {r[31:16], 16'hFFFF};
      4:       return BLOCK_W'(1) << $urandom_range(0, BLOCK_W - 1);
      default: return r;
    endcase
  endfunction

  task automatic random_blocks(int count);
    for (int i = 0; i < count; i++)
      send_block($urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT, pick_block());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset keys and delta, then the corners of both halves in each direction.
    send_block(CMD_ENCRYPT, 32'h0000_0000);
    send_block(CMD_DECRYPT, 32'h0000_0000);
    send_block(CMD_ENCRYPT, 32'hFFFF_FFFF);
    send_block(CMD_DECRYPT, 32'hFFFF_FFFF);
    send_block(CMD_ENCRYPT, 32'h0000_FFFF);
    send_block(CMD_DECRYPT, 32'h0000_FFFF);
    send_block(CMD_ENCRYPT, 32'hFFFF_0000);
    send_block(CMD_DECRYPT, 32'hFFFF_0000);
    send_block(CMD_ENCRYPT, 32'h8000_0001);
    send_block(CMD_DECRYPT, 32'h0001_8000);
    send_block(CMD_ENCRYPT, 32'hAAAA_5555);
    send_block(CMD_DECRYPT, 32'h5555_AAAA);
    send_block(CMD_ENCRYPT, 32'h0123_4567);
    send_block(CMD_DECRYPT, 32'h89AB_CDEF);
    wait_for_results();

    // Zero delta keeps the round sum at zero throughout.
    program_cipher(16'h0000, 16'h0000, 16'h0000);
    gaps_on = 1'b1;
    random_blocks(200);
    wait_for_results();

    program_cipher(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_blocks(200);
    wait_for_results();

    // Long output hold-off while the input keeps pushing, so the chain fills.
    program_cipher(16'hFFFF, 16'h0000, 16'h0001);
    gaps_on = 1'b0;
    hold_cycles = HOLD_LEN;
    random_blocks(200);
    wait_for_results();

    // A delta of 0x0800 flips the second key selection bit every round.
    program_cipher(16'h0000, 16'hFFFF, 16'h0800);
    gaps_on = 1'b1;
    random_blocks(200);
    wait_for_results();

    for (int p = 0; p < 3; p++) begin
      program_cipher(half_t'($urandom), half_t'($urandom), half_t'($urandom));
      gaps_on = ($urandom_range(0, 1) != 0);
      random_blocks(230);
      wait_for_results();
    end

    repeat (2 * ROUNDS + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("xtea16_block_cipher test passed");
    end else begin
      $display("xtea16_block_cipher test failed");
    end
    $finish;
  end

endmodule
